>>> rtl/qte_pkg.sv
// Shared constants, the arctangent table and the pipeline payload types of the converter.
package qte_pkg;

	// CORDIC step count and its table bound.
	localparam int CORDIC_STEPS = 16;
	localparam int TAB_LEN      = 24;
	localparam int CORDIC_N     = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;

	// Square root runs one result bit per cell over a 61-bit radicand.
	localparam int SQRT_STEPS = 31;
	localparam int SQRT_W     = 62;
	localparam int BITPOS_W   = 6;

	// Datapath widths.
	localparam int SUM_W   = 34;
	localparam int VEC_W   = 36;
	localparam int ANG_W   = 34;
	localparam int TAB_W   = 30;
	localparam int SHIFT_W = 5;
	localparam int OUT_W   = 16;
	localparam int LANES   = 3;

	// Lane numbers of the three angle chains.
	localparam int LANE_ROLL  = 0;
	localparam int LANE_PITCH = 1;
	localparam int LANE_YAW   = 2;

	// One in Q30, a quarter turn in accumulator units, and the saturated pitch.
	localparam logic signed [SUM_W-1:0] ONE_Q30      = SUM_W'(64'h4000_0000);
	localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(64'h4000_0000);
	localparam logic signed [ANG_W-1:0] ROUND_HALF   = ANG_W'(64'h0000_8000);
	localparam logic signed [OUT_W-1:0] PITCH_SAT    = OUT_W'(16384);

	// Arctangent of 2^-i with 2^31 standing for pi.
	function automatic logic [TAB_W-1:0] atan_entry(input int idx);
		logic [TAB_W-1:0] v;
		case (idx)
			0:  v = 30'h20000000;
			1:  v = 30'h12E4051E;
			2:  v = 30'h09FB385B;
			3:  v = 30'h051111D4;
			4:  v = 30'h028B0D43;
			5:  v = 30'h0145D7E1;
			6:  v = 30'h00A2F61E;
			7:  v = 30'h00517C55;
			8:  v = 30'h0028BE53;
			9:  v = 30'h00145F2F;
			10: v = 30'h000A2F98;
			11: v = 30'h000517CC;
			12: v = 30'h00028BE6;
			13: v = 30'h000145F3;
			14: v = 30'h0000A2FA;
			15: v = 30'h0000517D;
			16: v = 30'h000028BE;
			17: v = 30'h0000145F;
			18: v = 30'h00000A30;
			19: v = 30'h00000518;
			20: v = 30'h0000028C;
			21: v = 30'h00000146;
			22: v = 30'h000000A3;
			23: v = 30'h00000051;
			default: v = '0;
		endcase
		return v;
	endfunction

	// State handed from one CORDIC cell to the next.
	typedef struct packed {
		logic signed [VEC_W-1:0] x;
		logic signed [VEC_W-1:0] y;
		logic signed [ANG_W-1:0] z;
		logic                    zero;
		logic                    clamp;
		logic                    neg;
	} cordic_t;

	// State handed from one square root cell to the next, with the vectors riding along.
	typedef struct packed {
		logic        [SQRT_W-1:0] rem;
		logic        [SQRT_W-1:0] root;
		logic signed [SUM_W-1:0]  sinp;
		logic signed [SUM_W-1:0]  sinr;
		logic signed [SUM_W-1:0]  cosr;
		logic signed [SUM_W-1:0]  siny;
		logic signed [SUM_W-1:0]  cosy;
		logic                     clamp;
	} sqrt_t;

endpackage

>>> rtl/quaternion_to_euler_unit.sv
// Quaternion to roll, pitch and yaw converter: products, square root chain, three CORDIC chains.
//
//   channel | signals                                   | direction
//   input   | in_valid, in_stall, quat_w/x/y/z          | quaternion in
//   output  | out_valid, out_stall, roll/pitch/yaw_angle, pitch_clamped | angles out
//
// One quaternion is taken every cycle unless a result waits under out_stall; data passes the front
// stages, the 31 square root cells, the prerotation stage, the CORDIC cells and the output register.
// Reset clears only the valid bits of every stage.
// The whole pipeline holds while a result waits under out_stall; in_stall then is high.
module quaternion_to_euler_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [15:0]                quat_w,
	input  logic signed [15:0]                quat_x,
	input  logic signed [15:0]                quat_y,
	input  logic signed [15:0]                quat_z,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [15:0]                roll_angle,
	output logic signed [15:0]                pitch_angle,
	output logic signed [15:0]                yaw_angle,
	output logic                              pitch_clamped
);

	localparam int N = qte_pkg::CORDIC_N;

	// Prerotate vectors with x < 0 by a quarter turn and flag the zero vector.
	function automatic qte_pkg::cordic_t prerot(
		input logic signed [qte_pkg::SUM_W-1:0] yv,
		input logic signed [qte_pkg::SUM_W-1:0] xv,
		input logic                             clamp,
		input logic                             neg
	);
		qte_pkg::cordic_t                 r;
		logic signed [qte_pkg::VEC_W-1:0] xe;
		logic signed [qte_pkg::VEC_W-1:0] ye;
		xe      = qte_pkg::VEC_W'(xv);
		ye      = qte_pkg::VEC_W'(yv);
		r.x     = xe;
		r.y     = ye;
		r.z     = '0;
		r.zero  = (xv == '0) && (yv == '0);
		r.clamp = clamp;
		r.neg   = neg;
		if (xe[qte_pkg::VEC_W-1]) begin
			if (!ye[qte_pkg::VEC_W-1]) begin
				r.x = ye;
				r.y = -xe;
				r.z = qte_pkg::QUARTER_TURN;
			end else begin
				r.x = -ye;
				r.y = xe;
				r.z = -qte_pkg::QUARTER_TURN;
			end
		end
		return r;
	endfunction

	logic en;

	logic signed [31:0] p_wx_s1, p_yz_s1, p_xx_s1, p_yy_s1, p_zz_s1;
	logic signed [31:0] p_wy_s1, p_zx_s1, p_wz_s1, p_xy_s1;
	logic               v_s1;

	logic signed [qte_pkg::SUM_W-1:0] sinr_s2, cosr_s2, sinp_s2, siny_s2, cosy_s2;
	logic                             v_s2;

	logic                             clamp_c;
	logic signed [30:0]               sinp_c;
	logic signed [qte_pkg::SQRT_W-1:0] sinp_sq_c;
	qte_pkg::sqrt_t                   st_s3;
	qte_pkg::sqrt_t                   st4_c;
	qte_pkg::sqrt_t                   st_s4;
	logic                             v_s3, v_s4;

	qte_pkg::sqrt_t                   sq_d [qte_pkg::SQRT_STEPS+1];
	logic                             sq_v [qte_pkg::SQRT_STEPS+1];

	qte_pkg::cordic_t                 pre_q [qte_pkg::LANES];
	logic                             pre_valid_q;

	qte_pkg::cordic_t                 cr_d [qte_pkg::LANES][N+1];
	logic                             cr_v [qte_pkg::LANES][N+1];

	qte_pkg::sqrt_t                   sq_last;
	logic signed [qte_pkg::SUM_W-1:0] cosp;

	logic signed [qte_pkg::ANG_W-1:0] zr [qte_pkg::LANES];
	logic signed [15:0]               ang [qte_pkg::LANES];

	logic                             out_valid_q;
	logic signed [15:0]               roll_q, pitch_q, yaw_q;
	logic                             clamp_q;

	// The pipeline moves unless a result waits at a stalled output.
	assign en       = !(out_valid_q && out_stall);
	assign in_stall = out_valid_q && out_stall;

	// Stage one: all products of the components.
	always_ff @(posedge clk) begin
		if (en) begin
			p_wx_s1 <= quat_w * quat_x;
			p_yz_s1 <= quat_y * quat_z;
			p_xx_s1 <= quat_x * quat_x;
			p_yy_s1 <= quat_y * quat_y;
			p_zz_s1 <= quat_z * quat_z;
			p_wy_s1 <= quat_w * quat_y;
			p_zx_s1 <= quat_z * quat_x;
			p_wz_s1 <= quat_w * quat_z;
			p_xy_s1 <= quat_x * quat_y;
		end
	end

	// Stage two: sine and cosine terms in Q30.
	always_ff @(posedge clk) begin
		if (en) begin
			sinr_s2 <= (qte_pkg::SUM_W'(p_wx_s1) + qte_pkg::SUM_W'(p_yz_s1)) <<< 1;
			cosr_s2 <= qte_pkg::ONE_Q30
				- ((qte_pkg::SUM_W'(p_xx_s1) + qte_pkg::SUM_W'(p_yy_s1)) <<< 1);
			sinp_s2 <= (qte_pkg::SUM_W'(p_wy_s1) - qte_pkg::SUM_W'(p_zx_s1)) <<< 1;
			siny_s2 <= (qte_pkg::SUM_W'(p_wz_s1) + qte_pkg::SUM_W'(p_xy_s1)) <<< 1;
			cosy_s2 <= qte_pkg::ONE_Q30
				- ((qte_pkg::SUM_W'(p_yy_s1) + qte_pkg::SUM_W'(p_zz_s1)) <<< 1);
		end
	end

	// Stage three: saturation test and the square of the pitch sine.
	always_comb begin
		clamp_c   = (sinp_s2 >= qte_pkg::ONE_Q30) || (sinp_s2 <= -qte_pkg::ONE_Q30);
		sinp_c    = clamp_c ? '0 : sinp_s2[30:0];
		sinp_sq_c = qte_pkg::SQRT_W'(sinp_c) * qte_pkg::SQRT_W'(sinp_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s3.rem   <= $unsigned(sinp_sq_c);
			st_s3.root  <= '0;
			st_s3.sinp  <= sinp_s2;
			st_s3.sinr  <= sinr_s2;
			st_s3.cosr  <= cosr_s2;
			st_s3.siny  <= siny_s2;
			st_s3.cosy  <= cosy_s2;
			st_s3.clamp <= clamp_c;
		end
	end

	// Stage four: radicand 1 - s*s in Q60.
	always_comb begin
		st4_c     = st_s3;
		st4_c.rem = (qte_pkg::SQRT_W'(1) << 60) - st_s3.rem;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s4 <= st4_c;
		end
	end

	// Valid bits of the front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Square root chain, one result bit per cell.
	assign sq_d[0] = st_s4;
	assign sq_v[0] = v_s4;

	for (genvar k = 0; k < qte_pkg::SQRT_STEPS; k++) begin : g_sqrt
		qte_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (sq_v[k]),
			.in_data   (sq_d[k]),
			.bit_pos   (qte_pkg::BITPOS_W'(2 * (qte_pkg::SQRT_STEPS - 1 - k))),
			.out_valid (sq_v[k+1]),
			.out_data  (sq_d[k+1])
		);
	end

	// Prerotation stage feeding the three CORDIC chains.
	assign sq_last = sq_d[qte_pkg::SQRT_STEPS];
	assign cosp    = $signed(sq_last.root[qte_pkg::SUM_W-1:0]);

	always_ff @(posedge clk) begin
		if (en) begin
			pre_q[qte_pkg::LANE_ROLL]  <= prerot(sq_last.sinr, sq_last.cosr, 1'b0, 1'b0);
			pre_q[qte_pkg::LANE_PITCH] <= prerot(sq_last.sinp, cosp, sq_last.clamp,
				sq_last.sinp[qte_pkg::SUM_W-1]);
			pre_q[qte_pkg::LANE_YAW]   <= prerot(sq_last.siny, sq_last.cosy, 1'b0, 1'b0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_valid_q <= 1'b0;
		end else if (en) begin
			pre_valid_q <= sq_v[qte_pkg::SQRT_STEPS];
		end
	end

	// CORDIC chains, one table angle per cell.
	for (genvar l = 0; l < qte_pkg::LANES; l++) begin : g_lane
		assign cr_d[l][0] = pre_q[l];
		assign cr_v[l][0] = pre_valid_q;

		for (genvar k = 0; k < N; k++) begin : g_step
			qte_cordic_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.en        (en),
				.in_valid  (cr_v[l][k]),
				.in_data   (cr_d[l][k]),
				.shift     (qte_pkg::SHIFT_W'(k)),
				.angle     (qte_pkg::atan_entry(k)),
				.out_valid (cr_v[l][k+1]),
				.out_data  (cr_d[l][k+1])
			);
		end
	end

	// Round the accumulators to 16-bit binary angles.
	always_comb begin
		for (int l = 0; l < qte_pkg::LANES; l++) begin
			zr[l]  = cr_d[l][N].z + qte_pkg::ROUND_HALF;
			ang[l] = cr_d[l][N].zero ? '0 : $signed(zr[l][31:16]);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= cr_v[qte_pkg::LANE_ROLL][N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_q  <= ang[qte_pkg::LANE_ROLL];
			yaw_q   <= ang[qte_pkg::LANE_YAW];
			clamp_q <= cr_d[qte_pkg::LANE_PITCH][N].clamp;
			if (cr_d[qte_pkg::LANE_PITCH][N].clamp) begin
				pitch_q <= cr_d[qte_pkg::LANE_PITCH][N].neg ? -qte_pkg::PITCH_SAT
					: qte_pkg::PITCH_SAT;
			end else begin
				pitch_q <= ang[qte_pkg::LANE_PITCH];
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign roll_angle    = roll_q;
	assign pitch_angle   = pitch_q;
	assign yaw_angle     = yaw_q;
	assign pitch_clamped = clamp_q;

endmodule

>>> rtl/qte_sqrt_cell.sv
// One restoring square root cell: settles one result bit and passes the rest on.
module qte_sqrt_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  qte_pkg::sqrt_t                  in_data,
	input  logic [qte_pkg::BITPOS_W-1:0]    bit_pos,
	output logic                            out_valid,
	output qte_pkg::sqrt_t                  out_data
);

	logic [qte_pkg::SQRT_W-1:0] trial_bit;
	logic [qte_pkg::SQRT_W-1:0] trial_sum;
	qte_pkg::sqrt_t             nxt;

	// Subtract the trial value when it fits and shift the root.
	always_comb begin
		trial_bit = qte_pkg::SQRT_W'(1) << bit_pos;
		trial_sum = in_data.root + trial_bit;
		nxt = in_data;
		if (in_data.rem >= trial_sum) begin
			nxt.rem  = in_data.rem - trial_sum;
			nxt.root = (in_data.root >> 1) + trial_bit;
		end else begin
			nxt.root = in_data.root >> 1;
		end
	end

	// Stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= nxt;
		end
	end

endmodule

>>> rtl/qte_cordic_cell.sv
// One CORDIC vectoring cell: rotates toward the x axis by one table angle.
module qte_cordic_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  qte_pkg::cordic_t               in_data,
	input  logic [qte_pkg::SHIFT_W-1:0]    shift,
	input  logic [qte_pkg::TAB_W-1:0]      angle,
	output logic                           out_valid,
	output qte_pkg::cordic_t               out_data
);

	logic signed [qte_pkg::VEC_W-1:0] dx;
	logic signed [qte_pkg::VEC_W-1:0] dy;
	logic signed [qte_pkg::ANG_W-1:0] step;
	qte_pkg::cordic_t                 nxt;

	// Shifts floor toward minus infinity; the sign of y picks the direction.
	always_comb begin
		dx   = $signed(in_data.y) >>> shift;
		dy   = $signed(in_data.x) >>> shift;
		step = $signed({{(qte_pkg::ANG_W-qte_pkg::TAB_W){1'b0}}, angle});
		nxt  = in_data;
		if (!in_data.y[qte_pkg::VEC_W-1]) begin
			nxt.x = in_data.x + dx;
			nxt.y = in_data.y - dy;
			nxt.z = in_data.z + step;
		end else begin
			nxt.x = in_data.x - dx;
			nxt.y = in_data.y + dy;
			nxt.z = in_data.z - step;
		end
	end

	// Stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= nxt;
		end
	end

endmodule

>>> rtl/qte_checker.sv
// Port-level assertions for the converter and their bind to the top level.
module qte_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] roll_angle,
	input logic signed [15:0] pitch_angle,
	input logic signed [15:0] yaw_angle,
	input logic               pitch_clamped
);

	// A stalled result stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(roll_angle) && $stable(pitch_angle)
			&& $stable(yaw_angle) && $stable(pitch_clamped))
		else $error("stalled result changed");

	// The input is held back only by a result waiting at a stalled output.
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// A saturated pitch is exactly a quarter turn.
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pitch_clamped |-> pitch_angle == 16'sd16384 || pitch_angle == -16'sd16384)
		else $error("saturated pitch is not a quarter turn");

	// Pitch never leaves the half circle.
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pitch_angle <= 16'sd16384 && pitch_angle >= -16'sd16384)
		else $error("pitch out of range");

endmodule

bind quaternion_to_euler_unit qte_checker u_qte_checker (.*);

>>> test/quaternion_to_euler_unit_tb.sv
// Self-checking testbench for the quaternion to Euler angle converter.
module quaternion_to_euler_unit_tb;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 80;
	localparam int N_RANDOM       = 1050;

	// Idling phases.
	typedef enum int {PH_NONE, PH_SRC, PH_SNK, PH_BOTH} idle_phase_t;

	typedef struct packed {
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
		logic               clamped;
	} angles_t;

	typedef struct {
		logic signed [15:0] w, x, y, z;
		bit                 known;
		angles_t            ang;
	} quat_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [15:0] roll_angle, pitch_angle, yaw_angle;
	logic               pitch_clamped;

	angles_t     angles_due[$];
	int          fail_count = 0;
	int          quiet_cycles = 0;
	idle_phase_t phase = PH_NONE;
	bit          hold_sink = 1'b0;

	quaternion_to_euler_unit u_dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Floor shift of a signed value.
	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	// Floor integer square root.
	function automatic longint int_sqrt(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// Vectoring CORDIC giving a 16-bit binary angle.
	function automatic logic [15:0] vector_angle(longint yy, longint xx);
		longint acc, t, dx, dy;
		if (xx == 0 && yy == 0) return '0;
		acc = 0;
		if (xx < 0) begin
			t = xx;
			if (yy >= 0) begin
				xx = yy; yy = -t; acc = 64'sd1 << 30;
			end else begin
				xx = -yy; yy = t; acc = -(64'sd1 << 30);
			end
		end
		for (int i = 0; i < qte_pkg::CORDIC_N; i++) begin
			dx = floor_shr(yy, i);
			dy = floor_shr(xx, i);
			if (yy >= 0) begin
				xx += dx; yy -= dy; acc += longint'(qte_pkg::atan_entry(i));
			end else begin
				xx -= dx; yy += dy; acc -= longint'(qte_pkg::atan_entry(i));
			end
		end
		return 16'(floor_shr(acc + 32768, 16));
	endfunction

	// Euler angles of one quaternion.
	function automatic angles_t euler_of(longint w, longint x, longint y, longint z);
		angles_t a;
		longint one, sinr, cosr, sinp, siny, cosy, cosp;
		one  = 64'sd1 << 30;
		sinr = 2 * (w * x + y * z);
		cosr = one - 2 * (x * x + y * y);
		sinp = 2 * (w * y - z * x);
		siny = 2 * (w * z + x * y);
		cosy = one - 2 * (y * y + z * z);
		if (sinp >= one) begin
			a.pitch = 16'sd16384; a.clamped = 1'b1;
		end else if (sinp <= -one) begin
			a.pitch = -16'sd16384; a.clamped = 1'b1;
		end else begin
			cosp = int_sqrt((64'd1 << 60) - longint'(sinp * sinp));
			a.pitch = vector_angle(sinp, cosp);
			a.clamped = 1'b0;
		end
		a.roll = vector_angle(sinr, cosr);
		a.yaw  = vector_angle(siny, cosy);
		return a;
	endfunction

	// Drive one quaternion and wait for its transfer; valid stays up until the caller
	// offers the next item or drops it.
	task automatic send_quat(logic signed [15:0] w, x, y, z, bit known, angles_t ang);
		angles_t p;
		while ((phase == PH_SRC && $urandom_range(99) < 73) ||
			(phase == PH_BOTH && $urandom_range(99) < 15)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		p = euler_of(w, x, y, z);
		if (known && p != ang) begin
			$display("%0t: table row %0d %0d %0d %0d expected %h predictor %h",
				$time, w, x, y, z, ang, p);
			fail_count++;
		end
		angles_due.push_back(p);
		in_valid <= 1'b1;
		quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Mostly small components of magnitude at most 11585, with raw noise and extremes.
	function automatic logic [15:0] rand_comp(int kind);
		case (kind)
			0: return 16'($urandom);
			1: return 16'($urandom_range(65535) % 23170 - 11585);
			default: return ($urandom_range(1)) ? 16'h8000 : 16'h7FFF;
		endcase
	endfunction

	// Output side: stall and check transfers.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (angles_due.size() == 0) begin
				$display("%0t: unexpected transfer %0d %0d %0d %0d", $time,
					roll_angle, pitch_angle, yaw_angle, pitch_clamped);
				fail_count++;
			end else begin
				angles_t e;
				e = angles_due.pop_front();
				if (e.roll !== roll_angle) begin
					$display("%0t: roll expected %0d actual %0d", $time, e.roll, roll_angle);
					fail_count++;
				end
				if (e.pitch !== pitch_angle) begin
					$display("%0t: pitch expected %0d actual %0d", $time, e.pitch, pitch_angle);
					fail_count++;
				end
				if (e.yaw !== yaw_angle) begin
					$display("%0t: yaw expected %0d actual %0d", $time, e.yaw, yaw_angle);
					fail_count++;
				end
				if (e.clamped !== pitch_clamped) begin
					$display("%0t: clamp expected %0d actual %0d", $time, e.clamped,
						pitch_clamped);
					fail_count++;
				end
			end
		end
		out_stall <= hold_sink ||
			(phase == PH_SNK && $urandom_range(99) < 73) ||
			(phase == PH_BOTH && $urandom_range(99) < 15);
	end

	// Long receiver hold-off so the pipeline fills and backs up.
	initial begin
		wait (phase == PH_SNK);
		hold_sink = 1'b1;
		repeat (200) @(posedge clk);
		hold_sink = 1'b0;
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		quat_row_t rows[$];
		angles_t   none;
		int        kind;
		none = '0;
		// Identity, extremes, gimbal lock, half turn, zero vector.
		rows.push_back('{16'sh7FFF, 0, 0, 0, 0, none});
		rows.push_back('{0, 0, 0, 0, 1, '{0, 0, 0, 0}});
		rows.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 0, none});
		rows.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, none});
		rows.push_back('{16'sh5A82, 0, 16'sh5A82, 0, 0, none});
		rows.push_back('{16'sh5A82, 0, -16'sh5A82, 0, 0, none});
		rows.push_back('{16'sh4000, 16'sh4000, 16'sh4000, 16'sh4000, 0, none});
		rows.push_back('{0, 16'sh7FFF, 0, 0, 0, none});
		rows.push_back('{0, 0, 16'sh7FFF, 0, 0, none});
		rows.push_back('{0, 0, 0, 16'sh7FFF, 0, none});
		rows.push_back('{16'sh8000, 0, 0, 0, 0, none});
		rows.push_back('{0, 16'sh8000, 0, 0, 0, none});
		rows.push_back('{0, 0, 0, 16'sh8000, 0, none});
		rows.push_back('{16'sh5A82, 16'sh5A82, 0, 0, 0, none});
		rows.push_back('{16'sh5A82, 0, 0, 16'sh5A82, 0, none});
		rows.push_back('{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 0, none});
		rows.push_back('{16'sh0001, 16'shFFFF, 16'sh5555, 16'shAAAA, 0, none});
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send_quat(rows[i].w, rows[i].x, rows[i].y, rows[i].z, rows[i].known, rows[i].ang);
		// Random part over the idling phases.
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n % 210 == 0) phase = idle_phase_t'((n / 210) % 4);
			kind = $urandom_range(9);
			kind = (kind < 3) ? 0 : (kind < 9) ? 1 : 2;
			send_quat(rand_comp(kind), rand_comp(kind), rand_comp(kind), rand_comp(kind),
				0, none);
		end
		in_valid <= 1'b0;
		phase = PH_NONE;
		while (angles_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

>>> quaternion_to_euler_unit.f
rtl/qte_pkg.sv
rtl/qte_sqrt_cell.sv
rtl/qte_cordic_cell.sv
rtl/quaternion_to_euler_unit.sv
rtl/qte_checker.sv
test/quaternion_to_euler_unit_tb.sv
